>>> rtl/iiel_pkg.sv
// Shared types and constants for the indexed insert/erase list.
package iiel_pkg;

    localparam int DEPTH_DEFAULT     = 32;
    localparam int WORD_BITS_DEFAULT = 32;

    // Fixed field widths of the stream words.
    localparam int OPCODE_W = 3;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    // Slot numbers wide enough for any supported depth (up to 256 plus one).
    localparam int SLOT_W = 9;

    localparam int IN_TDATA_W  = ((POS_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_W + COUNT_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = OPCODE_W;
    localparam int OUT_TUSER_W = STATUS_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_INSERT = 3'd2,
        OP_ERASE  = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_READ   = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // What every cell of the row does at a clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_ERASE
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [SLOT_W-1:0]   slot;
    } cell_cmd_t;

endpackage

>>> rtl/iiel_cell.sv
// One storage cell of the list: holds one entry and trades it with its neighbors.
module iiel_cell #(
    parameter int WORD_BITS = iiel_pkg::WORD_BITS_DEFAULT,
    parameter int INDEX     = 0
) (
    input  logic                  clk,
    input  iiel_pkg::cell_cmd_t   cmd,
    input  logic [WORD_BITS-1:0]  word_new,
    input  logic [WORD_BITS-1:0]  left_word,
    input  logic [WORD_BITS-1:0]  right_word,
    output logic [WORD_BITS-1:0]  word,
    output logic [WORD_BITS-1:0]  read_word
);

    localparam int SLOT_W = iiel_pkg::SLOT_W;
    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

    logic [WORD_BITS-1:0] entry_reg;
    logic [WORD_BITS-1:0] entry_next;
    logic                 hit;
    logic                 above;

    assign hit   = (cmd.slot == MY_SLOT);
    assign above = (MY_SLOT > cmd.slot);

    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.op)
            iiel_pkg::CELL_WRITE:
            begin
                if (hit)
                begin
                    entry_next = word_new;
                end
            end
            iiel_pkg::CELL_INSERT:
            begin
                if (hit)
                begin
                    entry_next = word_new;
                end
                else if (above)
                begin
                    entry_next = left_word;
                end
            end
            iiel_pkg::CELL_ERASE:
            begin
                if (hit || above)
                begin
                    entry_next = right_word;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign word      = entry_reg;
    // Only the addressed cell puts its entry on the shared read bus.
    assign read_word = hit ? entry_reg : '0;

endmodule

>>> rtl/indexed_insert_erase_list_top.sv
// Top level of the indexed insert/erase list: control, row of cells and result register.
//
// This block keeps an ordered list of up to DEPTH words and an entry count. Each
// input word carries one operation (push, pop, insert at an index, erase at an
// index, clear, read at an index) and yields exactly one output word with the read
// value, the count after the operation and a status (ok, index out of range, full,
// empty). A failing operation leaves the list untouched. The list is a row of
// DEPTH identical cells, one entry each; every cell sees the same command and its
// two neighbors, so an insert or erase moves all later entries one place together.
// Each operation is decoded and applied at the edge it is accepted, and its result
// is registered in the output stage. The input is ready whenever the output
// register is empty or being drained, so a new word can be taken every cycle while
// the downstream side keeps up. Entries above the count are never read; their
// contents after reset are whatever the cells hold.
module indexed_insert_erase_list_top #(
    parameter int DEPTH     = iiel_pkg::DEPTH_DEFAULT,
    parameter int WORD_BITS = iiel_pkg::WORD_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0 up: position (5), word_in (32), zero fill (3).
    input  logic [iiel_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // Fields from bit 0 up: opcode (3).
    input  logic [iiel_pkg::IN_TUSER_W-1:0]      s_axis_tuser,

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0 up: word_out (32), count (6), zero fill (2).
    output logic [iiel_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // Fields from bit 0 up: status (2).
    output logic [iiel_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);

    localparam int POS_W   = iiel_pkg::POS_W;
    localparam int DATA_W  = iiel_pkg::DATA_W;
    localparam int COUNT_W = iiel_pkg::COUNT_W;
    localparam int SLOT_W  = iiel_pkg::SLOT_W;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam logic [SLOT_W-1:0] FULL_SLOTS = SLOT_W'(DEPTH);

    // Input fields.
    iiel_pkg::opcode_t     opcode;
    logic [POS_W-1:0]      position;
    logic [DATA_W-1:0]     word_in;
    logic                  accept;

    assign opcode   = iiel_pkg::opcode_t'(s_axis_tuser[iiel_pkg::OPCODE_W-1:0]);
    assign position = s_axis_tdata[POS_W-1:0];
    assign word_in  = s_axis_tdata[POS_W+DATA_W-1:POS_W];
    assign accept   = s_axis_tvalid && s_axis_tready;

    // Entry count.
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    logic [SLOT_W-1:0]     cnt_slot;
    logic [SLOT_W-1:0]     pos_slot;
    logic                  is_full;
    logic                  is_empty;

    assign cnt_slot = SLOT_W'(count_reg);
    assign pos_slot = SLOT_W'(position);
    assign is_full  = (cnt_slot == FULL_SLOTS);
    assign is_empty = (count_reg == '0);

    // Stored value is word_in kept in its low WORD_BITS bits.
    logic [WORD_BITS-1:0]  word_store;
    assign word_store = WORD_BITS'({{WORD_BITS{1'b0}}, word_in});

    // Decode: status, new count, command to the cell row, read enable.
    iiel_pkg::status_t     status;
    iiel_pkg::cell_cmd_t   cmd;
    logic                  read_ok;

    always_comb
    begin
        status     = iiel_pkg::ST_OK;
        count_next = count_reg;
        cmd.op     = iiel_pkg::CELL_HOLD;
        cmd.slot   = pos_slot;
        read_ok    = 1'b0;
        unique case (opcode)
            iiel_pkg::OP_PUSH:
            begin
                cmd.slot = cnt_slot;
                if (is_full)
                begin
                    status = iiel_pkg::ST_FULL;
                end
                else
                begin
                    cmd.op     = iiel_pkg::CELL_WRITE;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            iiel_pkg::OP_POP:
            begin
                if (is_empty)
                begin
                    status = iiel_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            iiel_pkg::OP_INSERT:
            begin
                // The index test comes before the full test.
                if (pos_slot > cnt_slot)
                begin
                    status = iiel_pkg::ST_RANGE;
                end
                else if (is_full)
                begin
                    status = iiel_pkg::ST_FULL;
                end
                else
                begin
                    cmd.op     = iiel_pkg::CELL_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            iiel_pkg::OP_ERASE:
            begin
                if (is_empty)
                begin
                    status = iiel_pkg::ST_EMPTY;
                end
                else if (pos_slot >= cnt_slot)
                begin
                    status = iiel_pkg::ST_RANGE;
                end
                else
                begin
                    cmd.op     = iiel_pkg::CELL_ERASE;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            iiel_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            iiel_pkg::OP_READ:
            begin
                if (is_empty)
                begin
                    status = iiel_pkg::ST_EMPTY;
                end
                else if (pos_slot >= cnt_slot)
                begin
                    status = iiel_pkg::ST_RANGE;
                end
                else
                begin
                    read_ok = 1'b1;
                end
            end
            default:
            begin
                // Unused opcodes do nothing and report ok.
                status = iiel_pkg::ST_OK;
            end
        endcase
        if (!accept)
        begin
            cmd.op     = iiel_pkg::CELL_HOLD;
            count_next = count_reg;
        end
    end

    // Row of cells. Each cell sees its left and right neighbor; the ends are tied off.
    logic [WORD_BITS-1:0]  cell_word [DEPTH];
    logic [WORD_BITS-1:0]  cell_read [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_w;
        logic [WORD_BITS-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_word[i+1];
        end

        iiel_cell #(
            .WORD_BITS (WORD_BITS),
            .INDEX     (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .word_new   (word_store),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[i]),
            .read_word  (cell_read[i])
        );
    end

    // The addressed cell alone drives a nonzero read word, so an OR collects it.
    logic [WORD_BITS-1:0]  read_bus;

    always_comb
    begin
        read_bus = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            read_bus = read_bus | cell_read[i];
        end
    end

    // Read result is sign-extended from WORD_BITS and cut to the output width.
    logic [DATA_W-1:0]     read_word;
    assign read_word = DATA_W'({{DATA_W{read_bus[WORD_BITS-1]}}, read_bus});

    // Output register.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DATA_W-1:0]     out_word_reg;
    logic [DATA_W-1:0]     out_word_next;
    logic [COUNT_W-1:0]    out_count_reg;
    logic [COUNT_W-1:0]    out_count_next;
    iiel_pkg::status_t     out_status_reg;
    iiel_pkg::status_t     out_status_next;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        if (accept)
        begin
            out_valid_next  = 1'b1;
            out_word_next   = read_ok ? read_word : '0;
            out_count_next  = COUNT_W'(count_next);
            out_status_next = status;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg   <= out_word_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = iiel_pkg::OUT_TDATA_W'({out_count_reg, out_word_reg});
    assign m_axis_tuser  = out_status_reg;

endmodule
